// ===== design/chained_hash_map_core_assert.svh =====
// Assertion macros used by the port checker file.
`ifndef CHAINED_HASH_MAP_CORE_ASSERT_SVH
`define CHAINED_HASH_MAP_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define CHM_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define CHM_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== design/chm_pkg.sv =====
// Package with commands and sequencer states of the chained hash map.
package chm_pkg;
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_ERASE  = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_READ,
    ST_CMP,
    ST_ALLOC,
    ST_UNLINK,
    ST_OUT
  } state_e;
endpackage

// ===== design/chained_hash_map_core.sv =====
// Top level of the chained hash map: sequencer, bucket table and node pool.
// Usage:
//  - Slave channel carries one command transaction: tdata holds command
//    (bits 1:0), key (33:2) and new_value (65:34), padded to 72 bits.
//  - Master channel returns one result transaction per command: tdata holds
//    hit (bit 0), found_value (32:1) and status (bit 33), padded to 40 bits.
//  - One command at a time: s_axis_tready is high only while the sequencer
//    idles. A command reads its bucket head, then walks the chain with a read
//    and a compare step per node until the match or the end; the node memory
//    read port (one read per step, registered data) sets this pace.
//    Insert of a new key on a recycled node adds one more memory read.
//    The unused command skips the walk and goes from the head step to output.
//  - The result sits in an output register; while m_axis_tready is low it
//    holds. The next command is still taken and walked, and waits at the end
//    of its sequence until the held result is taken.
//  - Reset clears the bucket valid bits, the fresh counter and the recycled
//    list at once; no clearing pass is needed. Node memories are not reset.
//  - Full pool: an insert of a new key is dropped with status set.
module chained_hash_map_core #(
  parameter int NUM_BUCKETS = 128,
  parameter int NUM_NODES   = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // command, key, new_value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // hit, found_value, status
);
  import chm_pkg::*;

  localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int NW = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;
  localparam int CW = $clog2(NUM_NODES + 1);

  // Bucket table: valid bits in flops, heads in a memory.
  logic [NUM_BUCKETS-1:0] bvalid_q;
  logic [NW-1:0] bhead_mem [NUM_BUCKETS];
  // Node pool: key, value, next link with its valid bit.
  logic [31:0]   nkey_mem [NUM_NODES];
  logic [31:0]   nval_mem [NUM_NODES];
  logic [NW:0]   nnext_mem [NUM_NODES];

  state_e state_q, state_d;
  logic [1:0]  cmd_q;
  logic [31:0] key_q, val_q;
  logic [BW-1:0] bkt_q;
  logic          cur_v_q, prev_v_q;
  logic [NW-1:0] cur_q, prev_q;
  logic [CW-1:0] steps_q, fresh_q;
  logic          free_v_q;
  logic [NW-1:0] free_q;
  // Registered read data.
  logic [NW-1:0] bhead_rd_q;
  logic [31:0]   rkey_q, rval_q;
  logic [NW:0]   rnext_q;
  logic          hit_q, status_q, out_v_q;
  logic [31:0]   fval_q;
  // Output register: holds the shown result while the next command runs.
  logic [33:0]   res_q;

  logic accept;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {6'd0, res_q};

  // Bucket head read address: the new bucket on the accepting edge.
  logic [BW-1:0] baddr;
  assign baddr = accept ? s_axis_tdata[2 +: BW] : bkt_q;

  // Node memory read address follows the sequencer.
  logic [NW-1:0] raddr;
  always_comb begin
    raddr = cur_q;
    if (state_q == ST_HEAD) raddr = bhead_rd_q;
    if (state_q == ST_ALLOC) raddr = free_q;
  end

  always_ff @(posedge clk_i) begin
    bhead_rd_q <= bhead_mem[baddr];
    rkey_q  <= nkey_mem[raddr];
    rval_q  <= nval_mem[raddr];
    rnext_q <= nnext_mem[raddr];
  end

  // Compare unit.
  logic match;
  assign match = (rkey_q == key_q);

  // A new key on a recycled node needs the node's link read first.
  logic need_alloc;
  assign need_alloc = (cmd_q == CMD_INSERT) && free_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (accept) state_d = ST_HEAD;
      ST_HEAD: begin
        if (cmd_q == CMD_NONE) state_d = ST_OUT;
        else if (bvalid_q[bkt_q]) state_d = ST_READ;
        else if (need_alloc) state_d = ST_ALLOC;
        else state_d = ST_UNLINK;
      end
      ST_READ:   state_d = ST_CMP;
      ST_CMP: begin
        if (match) state_d = ST_UNLINK;
        else if (!rnext_q[NW] || steps_q >= CW'(NUM_NODES - 1))
          state_d = need_alloc ? ST_ALLOC : ST_UNLINK;
        else state_d = ST_READ;
      end
      ST_ALLOC:  state_d = ST_UNLINK;
      ST_UNLINK: state_d = ST_OUT;
      ST_OUT:    if (!out_v_q || m_axis_tready) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bvalid_q <= '0;
      fresh_q  <= '0;
      free_v_q <= 1'b0;
      free_q   <= '0;
      out_v_q  <= 1'b0;
      res_q    <= '0;
      cur_v_q  <= 1'b0;
      prev_v_q <= 1'b0;
      steps_q  <= '0;
    end else begin
      // Show a finished result once the previous one is gone.
      if (state_q == ST_OUT && (!out_v_q || m_axis_tready)) out_v_q <= 1'b1;
      else if (m_axis_tready) out_v_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            cmd_q <= s_axis_tdata[1:0];
            key_q <= s_axis_tdata[33:2];
            val_q <= s_axis_tdata[65:34];
            bkt_q <= s_axis_tdata[2 +: BW];
            hit_q <= 1'b0;
            status_q <= 1'b0;
            fval_q <= '0;
            prev_v_q <= 1'b0;
            cur_v_q <= 1'b0;
            steps_q <= '0;
          end
        end
        ST_HEAD: begin
          cur_q   <= bhead_rd_q;
          cur_v_q <= bvalid_q[bkt_q];
        end
        ST_CMP: begin
          if (!match) begin
            if (rnext_q[NW] && steps_q < CW'(NUM_NODES - 1)) begin
              prev_q <= cur_q;
              prev_v_q <= 1'b1;
              cur_q <= rnext_q[NW-1:0];
              steps_q <= steps_q + 1'b1;
            end else begin
              // End of chain: append after the last node.
              prev_q <= cur_q;
              prev_v_q <= 1'b1;
              cur_v_q <= 1'b0;
            end
          end else begin
            // Capture the value of the match for a find; other commands get zero.
            fval_q <= (cmd_q == CMD_FIND) ? rval_q : 32'd0;
          end
        end
        ST_ALLOC: begin
        end
        ST_UNLINK: begin
          case (cmd_q)
            CMD_INSERT: begin
              if (cur_v_q) begin
                nval_mem[cur_q] <= val_q;
                hit_q <= 1'b1;
              end else if (free_v_q || fresh_q < CW'(NUM_NODES)) begin
                logic [NW-1:0] n;
                n = free_v_q ? free_q : fresh_q[NW-1:0];
                if (free_v_q) begin
                  free_v_q <= rnext_q[NW];
                  free_q <= rnext_q[NW-1:0];
                end else begin
                  fresh_q <= fresh_q + 1'b1;
                end
                nkey_mem[n] <= key_q;
                nval_mem[n] <= val_q;
                nnext_mem[n] <= '0;
                if (prev_v_q) nnext_mem[prev_q] <= {1'b1, n};
                else begin
                  bvalid_q[bkt_q] <= 1'b1;
                  bhead_mem[bkt_q] <= n;
                end
              end else begin
                status_q <= 1'b1;
              end
            end
            CMD_ERASE: begin
              if (cur_v_q) begin
                if (prev_v_q) nnext_mem[prev_q] <= rnext_q;
                else begin
                  bvalid_q[bkt_q] <= rnext_q[NW];
                  bhead_mem[bkt_q] <= rnext_q[NW-1:0];
                end
                nnext_mem[cur_q] <= {free_v_q, free_q};
                free_v_q <= 1'b1;
                free_q <= cur_q;
                hit_q <= 1'b1;
              end
            end
            CMD_FIND: hit_q <= cur_v_q;
            default: ;
          endcase
        end
        ST_OUT: begin
          if (!out_v_q || m_axis_tready) res_q <= {status_q, fval_q, hit_q};
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== design/chained_hash_map_core_chk.sv =====
// Port checker for the chained hash map, with its bind.
`include "chained_hash_map_core_assert.svh"
module chained_hash_map_core_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);
  `CHM_ASSERT_NXT(a_valid_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "drop")
  `CHM_ASSERT_NXT(a_busy_after, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready")
  `CHM_ASSERT_IMP(a_stat_hit, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[33], !m_axis_tdata[0], "hit and status")
  `CHM_ASSERT_NXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "hold")
endmodule

bind chained_hash_map_core chained_hash_map_core_chk u_chk (.*);

// ===== tb/sv/chm_checker.sv =====
// Checker for the chained hash map: predicts each result and compares it.
`timescale 1ns / 100ps
module chm_checker #(
  parameter int NUM_BUCKETS = 128,
  parameter int NUM_NODES   = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  output int          fail_count_o,
  output int          pending_o
);
  import chm_pkg::*;

  typedef struct packed {
    logic        status;
    logic [31:0] value;
    logic        hit;
  } lookup_t;

  localparam int BW = $clog2(NUM_BUCKETS);

  // Model of the map: bucket heads plus node pool with a recycled list.
  bit          head_ok[NUM_BUCKETS];
  int          head_idx[NUM_BUCKETS];
  logic [31:0] nkey[NUM_NODES];
  logic [31:0] nval[NUM_NODES];
  bit          nxt_ok[NUM_NODES];
  int          nxt_idx[NUM_NODES];
  int          fresh;
  bit          recyc_ok;
  int          recyc_head;

  lookup_t expected_q[$];

  function automatic lookup_t apply_command(cmd_e cmd, logic [31:0] k, logic [31:0] v);
    lookup_t r;
    int b, cur, prv, n;
    bit cur_ok, prv_ok;
    r = '0;
    b = int'(k[BW-1:0]);
    cur_ok = head_ok[b];
    cur = head_idx[b];
    prv_ok = 0;
    prv = 0;
    if (cmd == CMD_NONE) return r;
    while (cur_ok && nkey[cur] != k) begin
      prv_ok = 1;
      prv = cur;
      cur_ok = nxt_ok[cur];
      cur = nxt_idx[cur];
    end
    case (cmd)
      CMD_INSERT: begin
        if (cur_ok) begin
          nval[cur] = v;
          r.hit = 1;
        end else begin
          n = -1;
          if (recyc_ok) begin
            n = recyc_head;
            recyc_ok = nxt_ok[n];
            recyc_head = nxt_idx[n];
          end else if (fresh < NUM_NODES) begin
            n = fresh;
            fresh++;
          end
          if (n < 0) r.status = 1;
          else begin
            nkey[n] = k;
            nval[n] = v;
            nxt_ok[n] = 0;
            nxt_idx[n] = 0;
            if (prv_ok) begin
              nxt_ok[prv] = 1;
              nxt_idx[prv] = n;
            end else begin
              head_ok[b] = 1;
              head_idx[b] = n;
            end
          end
        end
      end
      CMD_ERASE: begin
        if (cur_ok) begin
          if (prv_ok) begin
            nxt_ok[prv] = nxt_ok[cur];
            nxt_idx[prv] = nxt_idx[cur];
          end else begin
            head_ok[b] = nxt_ok[cur];
            head_idx[b] = nxt_idx[cur];
          end
          nxt_ok[cur] = recyc_ok;
          nxt_idx[cur] = recyc_head;
          recyc_ok = 1;
          recyc_head = cur;
          r.hit = 1;
        end
      end
      default: begin
        if (cur_ok) begin
          r.hit = 1;
          r.value = nval[cur];
        end
      end
    endcase
    return r;
  endfunction

  lookup_t got, want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BUCKETS; i++) head_ok[i] = 0;
      fresh = 0;
      recyc_ok = 0;
      recyc_head = 0;
      expected_q.delete();
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      // Check first: a result can never belong to a command taken this edge.
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[33:0];
        if (expected_q.size() == 0) begin
          if (fail_count_o < 10) $display("ERROR: unexpected result %h", got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_q.pop_front();
          if (got.hit !== want.hit || got.value !== want.value
              || got.status !== want.status) begin
            if (fail_count_o < 10)
              $display("ERROR: hit/value/status expected %0b/%h/%0b got %0b/%h/%0b",
                       want.hit, want.value, want.status, got.hit, got.value, got.status);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_q.push_back(apply_command(cmd_e'(s_axis_tdata[1:0]),
                                           s_axis_tdata[33:2], s_axis_tdata[65:34]));
      pending_o <= expected_q.size();
    end
  end
endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top: drives hash map commands, stalls the result side, gives the verdict.
`timescale 1ns / 100ps
module tb_top;
  import chm_pkg::*;

  localparam int NUM_BUCKETS = 128;
  localparam int NUM_NODES   = 256;
  localparam int WATCHDOG    = 20000;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;  // command, key, new_value
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [39:0] m_axis_tdata;       // hit, found_value, status
  int          fail_count, pending;
  int          idle_cycles = 0;
  int          sent_count = 0;
  bit          timed_out = 0;
  logic [31:0] key_pool[16];

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  chained_hash_map_core #(.NUM_BUCKETS(NUM_BUCKETS), .NUM_NODES(NUM_NODES)) u_dut (.*);

  chm_checker #(.NUM_BUCKETS(NUM_BUCKETS), .NUM_NODES(NUM_NODES)) u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending));

  // Receiver: stall on a mode that the tick counter redraws at random, sometimes none.
  int rx_mode = 0, rx_tick = 0;
  always @(posedge clk_i) begin
    rx_tick <= rx_tick + 1;
    if (rx_tick % 64 == 0) rx_mode <= $urandom_range(0, 3);
    case (rx_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      2: m_axis_tready <= rx_tick[2];
      default: m_axis_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Watchdog: count cycles with no transaction on either channel.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else if (rst_ni) idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("watchdog expired");
      $display("FAIL");
      $finish;
    end
  end

  // Hold one command until it is taken.
  task automatic send_cmd(cmd_e cmd, logic [31:0] k, logic [31:0] v);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, v, k, cmd};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent_count++;
  endtask

  // Drop valid and wait a number of cycles.
  task automatic gap(int n);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Pick a key: mostly from a small pool that collides in a few buckets.
  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 9))
      0, 1: return $urandom();
      2:    return {25'($urandom_range(0, 3)), 7'd5};
      default: return key_pool[$urandom_range(0, 15)];
    endcase
  endfunction

  initial begin
    int burst;
    cmd_e c;
    for (int i = 0; i < 16; i++)
      key_pool[i] = {25'($urandom()), 7'd0} | 32'(i % 4);
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: misses on an empty map, extremes, collisions, replace, erase, unused command.
    send_cmd(CMD_FIND,   32'h0000_0000, 32'h0);
    send_cmd(CMD_ERASE,  32'h8000_0000, 32'h0);
    send_cmd(CMD_INSERT, 32'h8000_0000, 32'hFFFF_FFFF);
    send_cmd(CMD_INSERT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_cmd(CMD_INSERT, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_cmd(CMD_INSERT, 32'h0000_0000, 32'h0000_0000);
    send_cmd(CMD_INSERT, 32'h0000_0080, 32'h1234_5678);
    send_cmd(CMD_INSERT, 32'h0000_0100, 32'hA5A5_5A5A);
    send_cmd(CMD_FIND,   32'h0000_0100, 32'h0);
    send_cmd(CMD_INSERT, 32'h0000_0080, 32'h5555_AAAA);
    send_cmd(CMD_FIND,   32'h0000_0080, 32'h0);
    send_cmd(CMD_ERASE,  32'h0000_0080, 32'h0);
    send_cmd(CMD_FIND,   32'h0000_0080, 32'h0);
    send_cmd(CMD_ERASE,  32'h0000_0000, 32'h0);
    send_cmd(CMD_FIND,   32'h0000_0100, 32'h0);
    send_cmd(CMD_NONE,   32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_cmd(CMD_FIND,   32'hFFFF_FFFF, 32'h0);
    send_cmd(CMD_FIND,   32'h8000_0000, 32'h0);
    send_cmd(CMD_INSERT, 32'h0000_0180, 32'h0F0F_0F0F);
    // Wait for every result before the random part.
    gap(1);
    while (pending != 0) @(posedge clk_i);

    // Random: bursts and gaps; phase 1 fills the pool, phase 2 is mixed.
    for (int phase = 0; phase < 2; phase++) begin
      for (int n = 0; n < 600; ) begin
        burst = $urandom_range(1, 20);
        for (int j = 0; j < burst; j++, n++) begin
          case ($urandom_range(0, 19))
            0:           c = CMD_NONE;
            1, 2, 3, 4:  c = CMD_ERASE;
            5, 6, 7, 8,
            9, 10:       c = CMD_FIND;
            default:     c = CMD_INSERT;
          endcase
          if (phase == 0 && c == CMD_INSERT)
            send_cmd(c, $urandom(), $urandom());
          else
            send_cmd(c, pick_key(), $urandom());
        end
        if ($urandom_range(0, 2) != 0) gap($urandom_range(1, 12));
      end
      gap(1);
      while (pending != 0) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    $display("Sent %0d commands: inserts past a full pool, chain collisions,", sent_count);
    $display("replace, erase, find and the unused command under random stalls.");
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("FAIL");
    end
    $finish;
  end
endmodule
